// ===== sv/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared codes and default sizes for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int unsigned MAX_ORDERS_DEF = 32;
  localparam int unsigned PRICE_BITS_DEF = 16;
  localparam int unsigned QTY_BITS_DEF   = 16;
  localparam int unsigned ID_BITS_DEF    = 16;

  localparam int unsigned ARR_W    = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_LIMIT  = 2'd0;
  localparam cmd_t CMD_MARKET = 2'd1;
  localparam cmd_t CMD_CANCEL = 2'd2;
  localparam cmd_t CMD_UNUSED = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam status_t ST_RESTING   = 3'd0;
  localparam status_t ST_PARTIAL   = 3'd1;
  localparam status_t ST_FILLED    = 3'd2;
  localparam status_t ST_MKT_DROP  = 3'd3;
  localparam status_t ST_CANCELLED = 3'd4;
  localparam status_t ST_NOT_FOUND = 3'd5;
  localparam status_t ST_ZERO_QTY  = 3'd6;
  localparam status_t ST_BOOK_FULL = 3'd7;

endpackage

// ===== sv/limit_order_book_matcher.sv =====
// Sequence: each trade of a new order runs a best-entry scan, a trade issue and an
// output handshake; a final scan that finds no acceptable match leads a limit order
// into the free-slot search, and every command ends with the top-of-book scan; a
// cancel reports after its cancel scan and the top-of-book scan.
// Flow: one item at a time; the scans over the entry RAM set the pace.
// Reset: book empty, arrival counter and last trade price zero; no clearing pass.
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book: matches, rests, cancels, reports top of book.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int unsigned MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF,
  parameter int unsigned PRICE_BITS = lobm_pkg::PRICE_BITS_DEF,
  parameter int unsigned QTY_BITS   = lobm_pkg::QTY_BITS_DEF,
  parameter int unsigned ID_BITS    = lobm_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lobm_pkg::cmd_t                in_command,
  input  logic                          in_side,
  input  logic [PRICE_BITS-1:0]         in_limit_price,
  input  logic [QTY_BITS-1:0]           in_quantity,
  input  logic [ID_BITS-1:0]            in_order_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic [ID_BITS-1:0]            out_buyer_id,
  output logic [ID_BITS-1:0]            out_seller_id,
  output logic [PRICE_BITS-1:0]         out_trade_price,
  output logic [QTY_BITS-1:0]           out_trade_qty,
  output lobm_pkg::status_t             out_order_status,
  output logic [PRICE_BITS-1:0]         out_best_bid,
  output logic [QTY_BITS-1:0]           out_best_bid_volume,
  output logic [PRICE_BITS-1:0]         out_best_ask,
  output logic [QTY_BITS-1:0]           out_best_ask_volume,
  output logic [PRICE_BITS-1:0]         out_last_trade_price,
  output logic                          out_last
);

  import lobm_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ORDERS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_ORDERS);
  localparam int unsigned ENT_W = 1 + PRICE_BITS + QTY_BITS + ID_BITS + ARR_W;
  localparam int unsigned OFS_ID  = ARR_W;
  localparam int unsigned OFS_QTY = ARR_W + ID_BITS;
  localparam int unsigned OFS_PRC = ARR_W + ID_BITS + QTY_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_TRADE  = 3'd2;
  localparam logic [2:0] S_TWAIT  = 3'd3;
  localparam logic [2:0] S_CANCEL = 3'd4;
  localparam logic [2:0] S_FREE   = 3'd5;
  localparam logic [2:0] S_TOP    = 3'd6;
  localparam logic [2:0] S_STAT   = 3'd7;

  logic [2:0]            state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  pend_r;
  logic [IDX_W-1:0]      pidx_r;
  logic [MAX_ORDERS-1:0] valid_r;
  logic [ARR_W-1:0]      arr_cnt_r;
  logic [PRICE_BITS-1:0] recent_r;

  logic                  side_r;
  logic                  market_r;
  logic [PRICE_BITS-1:0] lim_r;
  logic [QTY_BITS-1:0]   rem_r;
  logic [ID_BITS-1:0]    id_r;
  logic                  traded_r;
  logic                  hit_r;
  status_t               status_r;

  logic                  bfound_r;
  logic [IDX_W-1:0]      bidx_r;
  logic [PRICE_BITS-1:0] bprice_r;
  logic [QTY_BITS-1:0]   brem_r;
  logic [ID_BITS-1:0]    bident_r;
  logic [ARR_W-1:0]      barr_r;
  logic [ARR_W-1:0]      bage_r;

  logic                  bid_found_r, ask_found_r;
  logic [PRICE_BITS-1:0] bid_px_r, ask_px_r;
  logic [QTY_BITS-1:0]   bid_vol_r, ask_vol_r;

  logic                  ov_r;
  logic                  okind_r;
  logic [ID_BITS-1:0]    obuy_r, osell_r;
  logic [PRICE_BITS-1:0] otpx_r;
  logic [QTY_BITS-1:0]   otqty_r;
  status_t               ostat_r;
  logic [PRICE_BITS-1:0] obb_r, oba_r, oltp_r;
  logic [QTY_BITS-1:0]   obbv_r, obav_r;
  logic                  olast_r;

  logic                  scanning;
  logic                  issue;
  logic                  scan_done;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic [ENT_W-1:0]      rd_data;
  logic                  e_side;
  logic [PRICE_BITS-1:0] e_price;
  logic [QTY_BITS-1:0]   e_rem;
  logic [ID_BITS-1:0]    e_ident;
  logic [ARR_W-1:0]      e_arr;
  logic [ARR_W-1:0]      e_age;
  logic                  opp;
  logic                  e_hit;
  logic                  e_better;
  logic [QTY_BITS-1:0]   fill;
  logic                  free_hit;
  logic                  price_bad;
  logic                  top_vld;
  logic                  top_better;
  logic [PRICE_BITS-1:0] top_px;
  logic                  top_found;
  logic [QTY_BITS-1:0]   top_vol;
  logic [QTY_BITS:0]     top_sum;
  logic [QTY_BITS-1:0]   top_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign scanning  = (state_r == S_MATCH) || (state_r == S_CANCEL) || (state_r == S_TOP);
  assign issue     = scanning && (cnt_r != CNT_END);
  assign scan_done = scanning && (cnt_r == CNT_END) && !pend_r;
  assign opp       = ~side_r;

  assign e_arr   = rd_data[ARR_W-1:0];
  assign e_ident = rd_data[OFS_ID +: ID_BITS];
  assign e_rem   = rd_data[OFS_QTY +: QTY_BITS];
  assign e_price = rd_data[OFS_PRC +: PRICE_BITS];
  assign e_side  = rd_data[ENT_W-1];
  assign e_age   = arr_cnt_r - e_arr;

  // best-entry candidate: better price, or same price and older
  assign e_hit    = pend_r && valid_r[pidx_r] && (e_side == opp);
  assign e_better = !bfound_r
                 || ((opp == SIDE_BUY) ? (e_price > bprice_r) : (e_price < bprice_r))
                 || ((e_price == bprice_r) && (e_age > bage_r));

  assign price_bad = !market_r &&
                     ((side_r == SIDE_BUY) ? (bprice_r > lim_r) : (bprice_r < lim_r));

  assign fill     = (rem_r < brem_r) ? rem_r : brem_r;
  assign free_hit = (state_r == S_FREE) && (cnt_r != CNT_END) && !valid_r[cnt_r[IDX_W-1:0]];

  // top-of-book per side
  assign top_vld    = pend_r && valid_r[pidx_r];
  assign top_found  = (e_side == SIDE_BUY) ? bid_found_r : ask_found_r;
  assign top_px     = (e_side == SIDE_BUY) ? bid_px_r : ask_px_r;
  assign top_vol    = (e_side == SIDE_BUY) ? bid_vol_r : ask_vol_r;
  assign top_better = !top_found ||
                      ((e_side == SIDE_BUY) ? (e_price > top_px) : (e_price < top_px));
  assign top_sum    = {1'b0, top_vol} + {1'b0, e_rem};
  assign top_sat    = top_sum[QTY_BITS] ? {QTY_BITS{1'b1}} : top_sum[QTY_BITS-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[IDX_W-1:0];
    wr_data = {side_r, lim_r, rem_r, id_r, arr_cnt_r};
    if (state_r == S_TRADE) begin
      wr_en   = 1'b1;
      wr_addr = bidx_r;
      wr_data = {opp, bprice_r, brem_r - fill, bident_r, barr_r};
    end else if (free_hit) begin
      wr_en = 1'b1;
    end
  end

  lobm_entry_ram #(
    .DEPTH  (MAX_ORDERS),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      valid_r   <= '0;
      arr_cnt_r <= '0;
      recent_r  <= '0;
      ov_r      <= 1'b0;
    end else begin
      pend_r <= issue;
      pidx_r <= cnt_r[IDX_W-1:0];
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            side_r   <= in_side;
            lim_r    <= in_limit_price;
            rem_r    <= in_quantity;
            id_r     <= in_order_id;
            market_r <= (in_command == CMD_MARKET) || (in_limit_price == '0);
            traded_r <= 1'b0;
            hit_r    <= 1'b0;
            bfound_r <= 1'b0;
            cnt_r    <= '0;
            bid_found_r <= 1'b0;
            ask_found_r <= 1'b0;
            bid_px_r <= '0;
            ask_px_r <= '0;
            bid_vol_r <= '0;
            ask_vol_r <= '0;
            if (in_command == CMD_UNUSED) begin
              status_r <= ST_NOT_FOUND;
              state_r  <= S_TOP;
            end else if (in_command == CMD_CANCEL) begin
              state_r <= S_CANCEL;
            end else if (in_quantity == '0) begin
              status_r <= ST_ZERO_QTY;
              state_r  <= S_TOP;
            end else begin
              state_r <= S_MATCH;
            end
          end
        end

        S_MATCH: begin
          if (e_hit && e_better) begin
            bfound_r <= 1'b1;
            bidx_r   <= pidx_r;
            bprice_r <= e_price;
            brem_r   <= e_rem;
            bident_r <= e_ident;
            barr_r   <= e_arr;
            bage_r   <= e_age;
          end
          if (scan_done) begin
            cnt_r <= '0;
            if (!bfound_r || price_bad) begin
              if (market_r) begin
                status_r <= ST_MKT_DROP;
                state_r  <= S_TOP;
              end else begin
                state_r <= S_FREE;
              end
            end else begin
              state_r <= S_TRADE;
            end
          end
        end

        S_TRADE: begin
          rem_r    <= rem_r - fill;
          traded_r <= 1'b1;
          recent_r <= bprice_r;
          if (brem_r == fill) begin
            valid_r[bidx_r] <= 1'b0;
          end
          ov_r    <= 1'b1;
          okind_r <= KIND_TRADE;
          obuy_r  <= (side_r == SIDE_BUY) ? id_r : bident_r;
          osell_r <= (side_r == SIDE_BUY) ? bident_r : id_r;
          otpx_r  <= bprice_r;
          otqty_r <= fill;
          ostat_r <= ST_RESTING;
          obb_r   <= '0;
          obbv_r  <= '0;
          oba_r   <= '0;
          obav_r  <= '0;
          oltp_r  <= '0;
          olast_r <= 1'b0;
          state_r <= S_TWAIT;
        end

        S_TWAIT: begin
          if (out_ready) begin
            ov_r     <= 1'b0;
            bfound_r <= 1'b0;
            cnt_r    <= '0;
            if (rem_r == '0) begin
              status_r <= ST_FILLED;
              state_r  <= S_TOP;
            end else begin
              state_r <= S_MATCH;
            end
          end
        end

        S_CANCEL: begin
          if (pend_r && valid_r[pidx_r] && (e_ident == id_r)) begin
            valid_r[pidx_r] <= 1'b0;
            hit_r <= 1'b1;
          end
          if (scan_done) begin
            cnt_r    <= '0;
            status_r <= hit_r ? ST_CANCELLED : ST_NOT_FOUND;
            state_r  <= S_TOP;
          end
        end

        S_FREE: begin
          if (cnt_r == CNT_END) begin
            cnt_r    <= '0;
            status_r <= ST_BOOK_FULL;
            state_r  <= S_TOP;
          end else if (free_hit) begin
            valid_r[cnt_r[IDX_W-1:0]] <= 1'b1;
            arr_cnt_r <= arr_cnt_r + 1'b1;
            cnt_r     <= '0;
            status_r  <= traded_r ? ST_PARTIAL : ST_RESTING;
            state_r   <= S_TOP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        S_TOP: begin
          if (top_vld) begin
            if (e_side == SIDE_BUY) begin
              bid_found_r <= 1'b1;
              if (top_better) begin
                bid_px_r  <= e_price;
                bid_vol_r <= e_rem;
              end else if (e_price == top_px) begin
                bid_vol_r <= top_sat;
              end
            end else begin
              ask_found_r <= 1'b1;
              if (top_better) begin
                ask_px_r  <= e_price;
                ask_vol_r <= e_rem;
              end else if (e_price == top_px) begin
                ask_vol_r <= top_sat;
              end
            end
          end
          if (scan_done) begin
            ov_r    <= 1'b1;
            okind_r <= KIND_STATUS;
            obuy_r  <= '0;
            osell_r <= '0;
            otpx_r  <= '0;
            otqty_r <= '0;
            ostat_r <= status_r;
            obb_r   <= bid_px_r;
            obbv_r  <= bid_vol_r;
            oba_r   <= ask_px_r;
            obav_r  <= ask_vol_r;
            oltp_r  <= recent_r;
            olast_r <= 1'b1;
            state_r <= S_STAT;
          end
        end

        S_STAT: begin
          if (out_ready) begin
            ov_r    <= 1'b0;
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = ov_r;
  assign out_result_kind      = okind_r;
  assign out_buyer_id         = obuy_r;
  assign out_seller_id        = osell_r;
  assign out_trade_price      = otpx_r;
  assign out_trade_qty        = otqty_r;
  assign out_order_status     = ostat_r;
  assign out_best_bid         = obb_r;
  assign out_best_bid_volume  = obbv_r;
  assign out_best_ask         = oba_r;
  assign out_best_ask_volume  = obav_r;
  assign out_last_trade_price = oltp_r;
  assign out_last             = olast_r;

endmodule

// ===== sv/lobm_entry_ram.sv =====
// ----------------------------------------------------------------------------
// lobm_entry_ram
// Resting order store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lobm_entry_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned DATA_W = 65
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
